// ----- rtl/vwt_pkg.sv -----
// ----------------------------------------------------------------------------
// vwt_pkg: shared types and constants for the vertex weld table
// Sizes of the vertex store, the point record and the sequencer states.
// ----------------------------------------------------------------------------
package vwt_pkg;

  // Vertex store size and the widths that follow from it
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned IdxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);

  // Field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 31;
  localparam int unsigned IdW    = 11;
  localparam int unsigned PointW = 3 * CoordW;

  localparam logic [CntW-1:0] MaxCount = CntW'(MaxVertices);

  // One point in signed Q16.16
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

endpackage

// ----- rtl/vertex_weld_table_unit.sv -----
// ----------------------------------------------------------------------------
// vertex_weld_table_unit: vertex welding with a per-axis tolerance
// Matches each incoming point against the stored vertices, or appends it while there is room.
// ----------------------------------------------------------------------------
// Each input beat is one point. The unit reads the stored vertices in
// insertion order, one per cycle from the single read port of the vertex
// store, and compares each against the point in one shared tolerance unit.
// The first match ends the scan. The input is not ready while a point is
// in work; a finished result waits in the output register while the next
// point is accepted and scanned, but that point's result is held until the
// last one is taken. The store needs no clearing after reset: only entries
// below the vertex count are ever read.
module vertex_weld_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Tolerance register write
  input  logic                          cfg_we_i,
  input  logic [vwt_pkg::TolW-1:0]      cfg_wdata_i,
  // Point input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [vwt_pkg::CoordW-1:0] x_i,
  input  logic signed [vwt_pkg::CoordW-1:0] y_i,
  input  logic signed [vwt_pkg::CoordW-1:0] z_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vwt_pkg::IdW-1:0]       vertex_id_o,
  output logic                          is_new_o,
  output logic                          table_full_o
);
  import vwt_pkg::*;

  state_e            state_q, state_d;
  logic [TolW-1:0]   tol_q;
  point_t            point_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   idx_q;
  logic              pend_q;
  logic [IdxW-1:0]   pend_idx_q;
  logic              found_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic              out_valid_q;
  logic [IdW-1:0]    vertex_id_q;
  logic              is_new_q;
  logic              table_full_q;

  logic [PointW-1:0] rd_data;
  logic              near;
  logic              hit;
  logic              accept;
  logic              rd_en;
  logic              scan_done;
  logic              finish_go;
  logic              room;
  logic              wr_en;

  // Vertex store
  vwt_vertex_ram #(
    .Width (PointW),
    .Depth (MaxVertices),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (point_q),
    .re_i    (rd_en),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  // Shared tolerance compare on the vertex read last cycle
  vwt_near_unit u_near (
    .point_i  (point_q),
    .vertex_i (point_t'(rd_data)),
    .tol_i    (tol_q),
    .near_o   (near)
  );

  assign hit       = pend_q & near;
  assign scan_done = (idx_q == count_q) & ~pend_q;
  assign room      = count_q < MaxCount;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        if (hit || scan_done) state_d = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    finish_go  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StScan: begin
        rd_en = ~hit & (idx_q < count_q);
      end
      StFinish: begin
        finish_go = ~out_valid_q | out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i & in_ready_o;
  assign wr_en  = finish_go & ~found_q & room;

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Vertex count: advance on append
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Scan control: restart on accept, advance one vertex per read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (accept) begin
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (state_q == StScan) begin
      pend_q <= rd_en;
      if (rd_en) idx_q <= idx_q + CntW'(1);
      if (hit) found_q <= 1'b1;
    end
  end

  // Scan payload: point, read index in flight, hit index
  always_ff @(posedge clk_i) begin
    if (accept) begin
      point_q <= '{x: x_i, y: y_i, z: z_i};
    end
    if (rd_en) begin
      pend_idx_q <= idx_q[IdxW-1:0];
    end
    if (hit) begin
      hit_idx_q <= pend_idx_q;
    end
  end

  // Output valid: set on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output beat payload
  always_ff @(posedge clk_i) begin
    if (finish_go) begin
      priority if (found_q) begin
        vertex_id_q  <= IdW'(hit_idx_q) + IdW'(1);
        is_new_q     <= 1'b0;
        table_full_q <= 1'b0;
      end else if (room) begin
        vertex_id_q  <= IdW'(count_q + CntW'(1));
        is_new_q     <= 1'b1;
        table_full_q <= 1'b0;
      end else begin
        vertex_id_q  <= '0;
        is_new_q     <= 1'b0;
        table_full_q <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_id_o  = vertex_id_q;
  assign is_new_o     = is_new_q;
  assign table_full_o = table_full_q;

endmodule

// ----- rtl/vwt_vertex_ram.sv -----
// ----------------------------------------------------------------------------
// vwt_vertex_ram: simple dual-port vertex store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vwt_vertex_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/vwt_near_unit.sv -----
// ----------------------------------------------------------------------------
// vwt_near_unit: per-axis tolerance compare
// Checks that each axis of a stored vertex lies within the tolerance of the
// probe point, using differences wide enough never to overflow.
// ----------------------------------------------------------------------------
module vwt_near_unit (
  input  vwt_pkg::point_t               point_i,
  input  vwt_pkg::point_t               vertex_i,
  input  logic [vwt_pkg::TolW-1:0]      tol_i,
  output logic                          near_o
);
  import vwt_pkg::*;

  localparam int unsigned DiffW = CoordW + 2;

  logic signed [DiffW-1:0] tol_pos;
  logic signed [DiffW-1:0] tol_neg;
  logic                    near_x;
  logic                    near_y;
  logic                    near_z;

  // Accept a difference in the closed range [-tol, tol]
  function automatic logic axis_near(input logic signed [CoordW-1:0] a,
                                     input logic signed [CoordW-1:0] b,
                                     input logic signed [DiffW-1:0]  lo,
                                     input logic signed [DiffW-1:0]  hi);
    logic signed [DiffW-1:0] diff;
    diff = DiffW'(a) - DiffW'(b);
    return (diff <= hi) && (diff >= lo);
  endfunction

  assign tol_pos = signed'({{(DiffW - TolW){1'b0}}, tol_i});
  assign tol_neg = -tol_pos;

  // Compare all three axes side by side
  assign near_x = axis_near(vertex_i.x, point_i.x, tol_neg, tol_pos);
  assign near_y = axis_near(vertex_i.y, point_i.y, tol_neg, tol_pos);
  assign near_z = axis_near(vertex_i.z, point_i.z, tol_neg, tol_pos);
  assign near_o = near_x & near_y & near_z;

endmodule
